FILE: rtl/core/sve_pkg.sv
package sve_pkg;

  localparam int CoordBits = 24;
  localparam int MsbBits   = $clog2(CoordBits);
  localparam int TenthBits = 2 * CoordBits + 1;
  localparam int NormShift = 14;
  localparam int NormBits  = 15;
  localparam int SqBits    = 31;
  localparam int ProdBits  = 31;
  localparam int RadBits   = 48;
  localparam int RootBits  = 24;
  localparam int NumBits   = 40;
  localparam int QuotBits  = 16;
  localparam int WideBits  = ((CoordBits + 1 > QuotBits + 2) ? CoordBits + 1 : QuotBits + 2) + 1;

  localparam int InDataBits  = ((4 * CoordBits + 9 + 7) / 8) * 8;
  localparam int OutDataBits = ((2 * CoordBits + 32 + 7) / 8) * 8;

  // ceil(2^(CoordBits+3) / 10), exact floor division for all magnitudes in range
  localparam logic [CoordBits-1:0] TenthRecip =
    CoordBits'(((64'd1 << (CoordBits + 3)) + 64'd9) / 64'd10);

  localparam logic [15:0] LineWidth = 16'd256;

  typedef enum logic [2:0] {
    CFG_RED   = 3'd0,
    CFG_GREEN = 3'd1,
    CFG_BLUE  = 3'd2,
    CFG_ALPHA = 3'd3,
    CFG_WIDTH = 3'd4
  } cfg_idx_t;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t                  x1;
    coord_t                  y1;
    logic signed [CoordBits:0] x2;
    logic signed [CoordBits:0] y2;
    logic [7:0]              alpha;
    logic                    neg_x;
    logic                    neg_y;
    logic                    zero;
  } side_t;

  typedef struct packed {
    logic [SqBits-1:0]   sq;
    logic [ProdBits-1:0] wx;
    logic [ProdBits-1:0] wy;
    side_t               side;
  } norm_t;

  typedef struct packed {
    logic [RootBits-1:0] len;
    logic [ProdBits-1:0] wx;
    logic [ProdBits-1:0] wy;
    side_t               side;
  } root_t;

  typedef struct packed {
    logic [QuotBits-1:0] ox_mag;
    logic [QuotBits-1:0] oy_mag;
    side_t               side;
  } quot_t;

endpackage

FILE: rtl/core/sve_front.sv
module sve_front import sve_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  coord_t        pos_x,
  input  coord_t        pos_y,
  input  coord_t        vel_x,
  input  coord_t        vel_y,
  input  logic [8:0]    life_progress,
  input  logic [7:0]    color_alpha,
  input  logic [15:0]   streak_width,
  output logic          out_valid,
  output norm_t         out_data
);

  // stage 1: magnitudes, tenth products, alpha product
  logic                   f1_valid_r;
  coord_t                 f1_x1_r, f1_y1_r;
  logic [CoordBits-1:0]   f1_mx_r, f1_my_r, f1_mx_nxt, f1_my_nxt;
  logic [TenthBits-1:0]   f1_tx_r, f1_ty_r, f1_tx_nxt, f1_ty_nxt;
  logic                   f1_neg_x_r, f1_neg_y_r;
  logic [16:0]            f1_aprod_r, f1_aprod_nxt;
  logic [8:0]             prog_c;

  always_comb begin
    f1_mx_nxt = vel_x[CoordBits-1] ? (~vel_x + CoordBits'(1)) : vel_x;
    f1_my_nxt = vel_y[CoordBits-1] ? (~vel_y + CoordBits'(1)) : vel_y;
    f1_tx_nxt = TenthBits'({1'b0, f1_mx_nxt} + (CoordBits+1)'(5)) * TenthBits'(TenthRecip);
    f1_ty_nxt = TenthBits'({1'b0, f1_my_nxt} + (CoordBits+1)'(5)) * TenthBits'(TenthRecip);
    prog_c = (life_progress > 9'd256) ? 9'd256 : life_progress;
    f1_aprod_nxt = 17'(color_alpha) * 17'(9'd256 - prog_c);
  end

  // stage 2: head point, faded alpha, leading one of the larger magnitude
  logic                   f2_valid_r;
  side_t                  f2_side_r, f2_side_nxt;
  logic [CoordBits-1:0]   f2_mx_r, f2_my_r, m_c;
  logic [MsbBits-1:0]     f2_msb_r, f2_msb_nxt;
  logic [TenthBits-CoordBits-4:0] qx_c, qy_c;
  logic [16:0]            around_c;

  always_comb begin
    qx_c = f1_tx_r[TenthBits-1:CoordBits+3];
    qy_c = f1_ty_r[TenthBits-1:CoordBits+3];
    f2_side_nxt.x1 = f1_x1_r;
    f2_side_nxt.y1 = f1_y1_r;
    f2_side_nxt.x2 = f1_neg_x_r ? ((CoordBits+1)'(f1_x1_r) - signed'((CoordBits+1)'(qx_c)))
                                : ((CoordBits+1)'(f1_x1_r) + signed'((CoordBits+1)'(qx_c)));
    f2_side_nxt.y2 = f1_neg_y_r ? ((CoordBits+1)'(f1_y1_r) - signed'((CoordBits+1)'(qy_c)))
                                : ((CoordBits+1)'(f1_y1_r) + signed'((CoordBits+1)'(qy_c)));
    around_c = f1_aprod_r + 17'd128;
    f2_side_nxt.alpha = around_c[15:8];
    f2_side_nxt.neg_x = f1_neg_x_r;
    f2_side_nxt.neg_y = f1_neg_y_r;
    m_c = (f1_mx_r > f1_my_r) ? f1_mx_r : f1_my_r;
    f2_side_nxt.zero = (m_c == '0);
    f2_msb_nxt = '0;
    for (int i = 0; i < CoordBits; i++) begin
      if (m_c[i]) f2_msb_nxt = MsbBits'(i);
    end
  end

  // stage 3: scale so the larger magnitude lands in [2^14, 2^15)
  logic                       f3_valid_r;
  side_t                      f3_side_r;
  logic [NormBits-1:0]        f3_mxn_r, f3_myn_r;
  logic [CoordBits+NormShift-1:0] shx_c, shy_c;

  always_comb begin
    shx_c = {f2_mx_r, NormShift'(0)} >> f2_msb_r;
    shy_c = {f2_my_r, NormShift'(0)} >> f2_msb_r;
  end

  // stage 4: squares and width products
  logic                 f4_valid_r;
  side_t                f4_side_r;
  logic [SqBits-2:0]    f4_sqx_r, f4_sqy_r;
  logic [ProdBits-1:0]  f4_wx_r, f4_wy_r;

  // stage 5: squared length
  logic                 f5_valid_r;
  norm_t                f5_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
      f4_valid_r <= 1'b0;
      f5_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
      f4_valid_r <= f3_valid_r;
      f5_valid_r <= f4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_x1_r    <= pos_x;
      f1_y1_r    <= pos_y;
      f1_mx_r    <= f1_mx_nxt;
      f1_my_r    <= f1_my_nxt;
      f1_tx_r    <= f1_tx_nxt;
      f1_ty_r    <= f1_ty_nxt;
      f1_neg_x_r <= vel_x[CoordBits-1];
      f1_neg_y_r <= vel_y[CoordBits-1];
      f1_aprod_r <= f1_aprod_nxt;

      f2_side_r <= f2_side_nxt;
      f2_mx_r   <= f1_mx_r;
      f2_my_r   <= f1_my_r;
      f2_msb_r  <= f2_msb_nxt;

      f3_side_r <= f2_side_r;
      f3_mxn_r  <= shx_c[NormBits-1:0];
      f3_myn_r  <= shy_c[NormBits-1:0];

      f4_side_r <= f3_side_r;
      f4_sqx_r  <= (SqBits-1)'(f3_mxn_r) * (SqBits-1)'(f3_mxn_r);
      f4_sqy_r  <= (SqBits-1)'(f3_myn_r) * (SqBits-1)'(f3_myn_r);
      f4_wx_r   <= ProdBits'(f3_mxn_r) * ProdBits'(streak_width);
      f4_wy_r   <= ProdBits'(f3_myn_r) * ProdBits'(streak_width);

      f5_data_r.sq   <= SqBits'(f4_sqx_r) + SqBits'(f4_sqy_r);
      f5_data_r.wx   <= f4_wx_r;
      f5_data_r.wy   <= f4_wy_r;
      f5_data_r.side <= f4_side_r;
    end
  end

  assign out_valid = f5_valid_r;
  assign out_data  = f5_data_r;

endmodule

FILE: rtl/core/sve_sqrt.sv
module sve_sqrt import sve_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  norm_t  in_data,
  output logic   out_valid,
  output root_t  out_data
);

  typedef struct packed {
    logic [RadBits-1:0]  rem;
    logic [RootBits-1:0] root;
    logic [ProdBits-1:0] wx;
    logic [ProdBits-1:0] wy;
    side_t               side;
  } sq_stage_t;

  sq_stage_t            st_r   [RootBits];
  sq_stage_t            st_nxt [RootBits];
  sq_stage_t            prev_c [RootBits];
  logic [RadBits-1:0]   trial_c [RootBits];
  logic [RootBits-1:0]  vld_r;

  // one root bit per stage, msb first
  always_comb begin
    prev_c[0].rem  = {RadBits'(in_data.sq) << 16};
    prev_c[0].root = '0;
    prev_c[0].wx   = in_data.wx;
    prev_c[0].wy   = in_data.wy;
    prev_c[0].side = in_data.side;
    for (int k = 1; k < RootBits; k++) begin
      prev_c[k] = st_r[k-1];
    end
    for (int k = 0; k < RootBits; k++) begin
      trial_c[k] = (RadBits'(prev_c[k].root) << (RootBits - k))
                 + (RadBits'(1) << (2 * (RootBits - 1 - k)));
      st_nxt[k] = prev_c[k];
      if (prev_c[k].rem >= trial_c[k]) begin
        st_nxt[k].rem  = prev_c[k].rem - trial_c[k];
        st_nxt[k].root = prev_c[k].root | (RootBits'(1) << (RootBits - 1 - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[RootBits-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < RootBits; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid     = vld_r[RootBits-1];
  assign out_data.len  = st_r[RootBits-1].root;
  assign out_data.wx   = st_r[RootBits-1].wx;
  assign out_data.wy   = st_r[RootBits-1].wy;
  assign out_data.side = st_r[RootBits-1].side;

endmodule

FILE: rtl/core/sve_div.sv
module sve_div import sve_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  root_t  in_data,
  output logic   out_valid,
  output quot_t  out_data
);

  typedef struct packed {
    logic [NumBits-1:0]  rem_ox;
    logic [NumBits-1:0]  rem_oy;
    logic [QuotBits-1:0] q_ox;
    logic [QuotBits-1:0] q_oy;
    logic [RootBits-1:0] den;
    side_t               side;
  } dv_stage_t;

  // numerator setup: (w << 8) + len / 2
  logic       d0_valid_r;
  dv_stage_t  d0_r, d0_nxt;

  always_comb begin
    d0_nxt.rem_ox = (NumBits'(in_data.wy) << 8) + NumBits'(in_data.len >> 1);
    d0_nxt.rem_oy = (NumBits'(in_data.wx) << 8) + NumBits'(in_data.len >> 1);
    d0_nxt.q_ox   = '0;
    d0_nxt.q_oy   = '0;
    d0_nxt.den    = in_data.len;
    d0_nxt.side   = in_data.side;
  end

  // restoring division, one quotient bit per stage for both lanes
  dv_stage_t            st_r   [QuotBits];
  dv_stage_t            st_nxt [QuotBits];
  dv_stage_t            prev_c [QuotBits];
  logic [NumBits-1:0]   dsh_c  [QuotBits];
  logic [QuotBits-1:0]  vld_r;

  always_comb begin
    prev_c[0] = d0_r;
    for (int k = 1; k < QuotBits; k++) begin
      prev_c[k] = st_r[k-1];
    end
    for (int k = 0; k < QuotBits; k++) begin
      dsh_c[k]  = NumBits'(prev_c[k].den) << (QuotBits - 1 - k);
      st_nxt[k] = prev_c[k];
      if (prev_c[k].rem_ox >= dsh_c[k]) begin
        st_nxt[k].rem_ox = prev_c[k].rem_ox - dsh_c[k];
        st_nxt[k].q_ox   = prev_c[k].q_ox | (QuotBits'(1) << (QuotBits - 1 - k));
      end
      if (prev_c[k].rem_oy >= dsh_c[k]) begin
        st_nxt[k].rem_oy = prev_c[k].rem_oy - dsh_c[k];
        st_nxt[k].q_oy   = prev_c[k].q_oy | (QuotBits'(1) << (QuotBits - 1 - k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_valid_r <= 1'b0;
      vld_r      <= '0;
    end else if (adv) begin
      d0_valid_r <= in_valid;
      vld_r      <= {vld_r[QuotBits-2:0], d0_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r <= d0_nxt;
      for (int k = 0; k < QuotBits; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid       = vld_r[QuotBits-1];
  assign out_data.ox_mag = st_r[QuotBits-1].q_ox;
  assign out_data.oy_mag = st_r[QuotBits-1].q_oy;
  assign out_data.side   = st_r[QuotBits-1].side;

endmodule

FILE: rtl/core/sve_out.sv
module sve_out import sve_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  quot_t         in_data,
  input  logic [7:0]    color_red,
  input  logic [7:0]    color_green,
  input  logic [7:0]    color_blue,
  input  logic [15:0]   streak_width,
  output logic          adv,
  output logic          out_valid,
  input  logic          out_ready,
  output coord_t        vertex_x,
  output coord_t        vertex_y,
  output logic [7:0]    vertex_red,
  output logic [7:0]    vertex_green,
  output logic [7:0]    vertex_blue,
  output logic [7:0]    vertex_alpha,
  output logic          triangle_mode,
  output logic          last_vertex
);

  localparam logic signed [WideBits-1:0] CoordHi =
    WideBits'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
  localparam logic signed [WideBits-1:0] CoordLo = -CoordHi - WideBits'(1);

  function automatic coord_t sat_coord(input logic signed [WideBits-1:0] v);
    coord_t r;
    if (v > CoordHi) r = CoordHi[CoordBits-1:0];
    else if (v < CoordLo) r = CoordLo[CoordBits-1:0];
    else r = v[CoordBits-1:0];
    return r;
  endfunction

  // corner stage: v1 = tail+(ox,-oy), v2 = tail-(ox,-oy), v3 = head-(ox,-oy), v4 = head+(ox,-oy)
  // in line mode the offsets are forced to zero so v4 is the head and v1 the tail
  logic                         e_valid_r;
  coord_t                       vx_r [4];
  coord_t                       vy_r [4];
  coord_t                       vx_nxt [4];
  coord_t                       vy_nxt [4];
  logic [7:0]                   e_alpha_r;
  logic                         e_tri_r, tri_c;
  logic signed [WideBits-1:0]   ox_c, oy_c, x1_c, y1_c, x2_c, y2_c;

  always_comb begin
    tri_c = (streak_width != LineWidth);
    x1_c  = WideBits'(in_data.side.x1);
    y1_c  = WideBits'(in_data.side.y1);
    x2_c  = WideBits'(in_data.side.x2);
    y2_c  = WideBits'(in_data.side.y2);
    ox_c  = signed'(WideBits'(in_data.ox_mag));
    oy_c  = signed'(WideBits'(in_data.oy_mag));
    if (!tri_c || in_data.side.zero) begin
      ox_c = '0;
      oy_c = '0;
    end
    if (in_data.side.neg_y) ox_c = -ox_c;
    if (in_data.side.neg_x) oy_c = -oy_c;
    vx_nxt[0] = sat_coord(x1_c + ox_c);
    vy_nxt[0] = sat_coord(y1_c - oy_c);
    vx_nxt[1] = sat_coord(x1_c - ox_c);
    vy_nxt[1] = sat_coord(y1_c + oy_c);
    vx_nxt[2] = sat_coord(x2_c - ox_c);
    vy_nxt[2] = sat_coord(y2_c + oy_c);
    vx_nxt[3] = sat_coord(x2_c + ox_c);
    vy_nxt[3] = sat_coord(y2_c - oy_c);
  end

  // vertex sequencer
  logic [2:0]   idx_r;
  logic [1:0]   sel_c;
  logic         head_c, last_c, load_c;

  always_comb begin
    sel_c  = 2'd0;
    last_c = 1'b0;
    if (e_tri_r) begin
      case (idx_r)
        3'd0: sel_c = 2'd0;
        3'd1: sel_c = 2'd3;
        3'd2: sel_c = 2'd1;
        3'd3: sel_c = 2'd3;
        3'd4: sel_c = 2'd2;
        3'd5: begin
          sel_c  = 2'd1;
          last_c = 1'b1;
        end
        default: sel_c = 2'd0;
      endcase
    end else begin
      case (idx_r)
        3'd0: sel_c = 2'd3;
        3'd1: begin
          sel_c  = 2'd0;
          last_c = 1'b1;
        end
        default: sel_c = 2'd0;
      endcase
    end
    head_c = sel_c[1];
    load_c = e_valid_r && (!out_valid || out_ready);
    adv    = !e_valid_r || (load_c && last_c);
  end

  logic         out_valid_r;
  coord_t       vertex_x_r, vertex_y_r;
  logic [7:0]   red_r, green_r, blue_r, alpha_r;
  logic         tri_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (adv) e_valid_r <= in_valid;
      if (load_c) begin
        out_valid_r <= 1'b1;
        idx_r       <= last_c ? 3'd0 : idx_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        vx_r[i] <= vx_nxt[i];
        vy_r[i] <= vy_nxt[i];
      end
      e_alpha_r <= in_data.side.alpha;
      e_tri_r   <= tri_c;
    end
    if (load_c) begin
      vertex_x_r <= vx_r[sel_c];
      vertex_y_r <= vy_r[sel_c];
      red_r      <= head_c ? color_red   : 8'd0;
      green_r    <= head_c ? color_green : 8'd0;
      blue_r     <= head_c ? color_blue  : 8'd0;
      alpha_r    <= head_c ? e_alpha_r   : 8'd0;
      tri_r      <= e_tri_r;
      last_r     <= last_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign vertex_x      = vertex_x_r;
  assign vertex_y      = vertex_y_r;
  assign vertex_red    = red_r;
  assign vertex_green  = green_r;
  assign vertex_blue   = blue_r;
  assign vertex_alpha  = alpha_r;
  assign triangle_mode = tri_r;
  assign last_vertex   = last_r;

endmodule

FILE: rtl/core/spark_segment_vertex_expander.sv
// Spark streak vertex expander. Each particle beat yields six triangle vertices
// (v1,v4,v2,v4,v3,v2), or two line vertices (head, tail) when streak_width is 256.
// All vertices leave on the single result port, one per cycle while out_tready
// is high; the pipeline behind it accepts a new particle as soon as the last
// vertex of the previous one is loaded into the output register. The delay from
// input beat to first vertex comes from the 24 stage square root and the 16
// stage divider that turn the velocity into a unit normal. Write the color and
// width registers only while idle.
module spark_segment_vertex_expander import sve_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // pos_x, pos_y, vel_x, vel_y, life_progress
  input  logic [InDataBits-1:0]   in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // vertex_x, vertex_y, vertex_red, vertex_green, vertex_blue, vertex_alpha
  output logic [OutDataBits-1:0]  out_tdata,
  // triangle_mode
  output logic                    out_tuser,
  output logic                    out_tlast
);

  logic [7:0]  color_red_r, color_green_r, color_blue_r, color_alpha_r;
  logic [15:0] streak_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_red_r    <= 8'd255;
      color_green_r  <= 8'd255;
      color_blue_r   <= 8'd255;
      color_alpha_r  <= 8'd255;
      streak_width_r <= LineWidth;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RED:   color_red_r    <= cfg_wdata[7:0];
        CFG_GREEN: color_green_r  <= cfg_wdata[7:0];
        CFG_BLUE:  color_blue_r   <= cfg_wdata[7:0];
        CFG_ALPHA: color_alpha_r  <= cfg_wdata[7:0];
        CFG_WIDTH: streak_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic   adv;
  logic   norm_valid, root_valid, quot_valid;
  norm_t  norm_data;
  root_t  root_data;
  quot_t  quot_data;
  coord_t vertex_x, vertex_y;
  logic [7:0] vertex_red, vertex_green, vertex_blue, vertex_alpha;

  assign in_tready = adv;

  sve_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_tvalid),
    .pos_x         (coord_t'(in_tdata[CoordBits-1:0])),
    .pos_y         (coord_t'(in_tdata[2*CoordBits-1:CoordBits])),
    .vel_x         (coord_t'(in_tdata[3*CoordBits-1:2*CoordBits])),
    .vel_y         (coord_t'(in_tdata[4*CoordBits-1:3*CoordBits])),
    .life_progress (in_tdata[4*CoordBits+8:4*CoordBits]),
    .color_alpha   (color_alpha_r),
    .streak_width  (streak_width_r),
    .out_valid     (norm_valid),
    .out_data      (norm_data)
  );

  sve_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (norm_valid),
    .in_data   (norm_data),
    .out_valid (root_valid),
    .out_data  (root_data)
  );

  sve_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (root_valid),
    .in_data   (root_data),
    .out_valid (quot_valid),
    .out_data  (quot_data)
  );

  sve_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (quot_valid),
    .in_data       (quot_data),
    .color_red     (color_red_r),
    .color_green   (color_green_r),
    .color_blue    (color_blue_r),
    .streak_width  (streak_width_r),
    .adv           (adv),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_red    (vertex_red),
    .vertex_green  (vertex_green),
    .vertex_blue   (vertex_blue),
    .vertex_alpha  (vertex_alpha),
    .triangle_mode (out_tuser),
    .last_vertex   (out_tlast)
  );

  assign out_tdata = OutDataBits'({vertex_alpha, vertex_blue, vertex_green, vertex_red,
                                   vertex_y, vertex_x});

endmodule
